>>> hw/rtl/btpc_pkg.sv
package btpc_pkg;

    // Fixed block constants.
    localparam int unsigned AVERAGE_LENGTH    = 10;
    localparam int unsigned DUTY_STEPS        = 30;
    localparam int unsigned SAMPLE_FULL_SCALE = 4095;
    localparam int unsigned PERCENT_SCALE     = 100;

    // Field and register widths.
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned DUTY_W     = 5;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned MARGIN_W   = 4;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned CYCLE_W    = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned RING_IDX_W = $clog2(AVERAGE_LENGTH);

    // Width of avg * 30 ahead of the divide by full scale.
    localparam int unsigned DUTY_PROD_W = SAMPLE_W + DUTY_W;

    // Division by ten of a 16-bit sum: (x * 52429) >> 19 is exact for all x < 2^16.
    localparam int unsigned AVG_RECIP_W = 16;
    localparam int unsigned AVG_RECIP   = 52429;
    localparam int unsigned AVG_SHIFT   = 19;

    // Slot length is cycle / 30 = (cycle >> 1) / 15, and (y * 559241) >> 23 is an
    // exact divide by fifteen for every 19-bit y.
    localparam int unsigned SLOT_RECIP_W = 20;
    localparam int unsigned SLOT_RECIP   = 559241;
    localparam int unsigned SLOT_SHIFT   = 23;
    localparam int unsigned SLOT_W       = 16;
    localparam int unsigned HALF_W       = CYCLE_W - 1;
    localparam int unsigned HALF_LO_W    = 10;
    localparam int unsigned HALF_HI_W    = HALF_W - HALF_LO_W;
    localparam int unsigned SLOT_PROD_W  = HALF_W + SLOT_RECIP_W;

    // Divide by thirty for the percent: (x * 4370) >> 17 is exact for every x below
    // 4681, and x = duty * 100 stays at or below 3000.
    localparam int unsigned PCT_RECIP  = 4370;
    localparam int unsigned PCT_SHIFT  = 17;
    localparam int unsigned PCT_PROD_W = 24;

    // Reset values of the configuration registers.
    localparam int unsigned MARGIN_RESET   = 2;
    localparam int unsigned DEBOUNCE_RESET = 50;
    localparam int unsigned CYCLE_RESET    = 30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HYSTERESIS = 2'd0,
        CFG_DEBOUNCE   = 2'd1,
        CFG_CYCLE      = 2'd2
    } t_cfg_idx;

    // Truncated percent of a duty level through a constant reciprocal multiply.
    function automatic logic [PCT_W-1:0] pct_of_duty(input logic [DUTY_W-1:0] duty);
        logic [PCT_PROD_W-1:0] v;
        v = PCT_PROD_W'(duty) * PCT_PROD_W'(PERCENT_SCALE * PCT_RECIP);
        return v[PCT_SHIFT +: PCT_W];
    endfunction

endpackage

>>> hw/rtl/burner_time_proportioning_channel.sv
// Time-proportioning relay channel for one heating element.
//
// Input items arrive on the s_axis channel: each carries a millisecond timestamp
// and a 12-bit potentiometer sample. Every input item gives exactly one result
// item on the m_axis channel with the relay state, the held duty level, the duty
// as a percent and the ten-sample moving average.
//
// The block is a five-register pipeline (input, ring update, average, raw duty,
// output register). One item is accepted in every cycle while results are being
// taken. The hysteresis and relay decisions sit in the last stage, so consecutive
// items never wait on each other.
//
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// once the output register is full; nothing is dropped or repeated.
// Reset clears the sample ring, running sum, held duty, relay and time marks, and
// loads the register defaults (margin 2, debounce 50 ms, cycle 30000 ms).
// Registers are written through the plain write port; the user must write them
// only while no item is in flight, which the block itself does not enforce.
module burner_time_proportioning_channel
    import btpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CYCLE_W-1:0]    i_cfg_wdata,
    // Input items.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,   // now_ms[31:0], adc_sample[43:32]
    // Result items.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata    // relay_on[0], duty_level[5:1],
                                                  // power_percent[12:6],
                                                  // average_sample[24:13]
);

    // Configuration registers.
    logic [MARGIN_W-1:0]   r_margin;
    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [CYCLE_W-1:0]    r_cycle_len;
    logic [SLOT_W-1:0]     w_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin    <= MARGIN_W'(MARGIN_RESET);
            r_debounce  <= DEBOUNCE_W'(DEBOUNCE_RESET);
            r_cycle_len <= CYCLE_W'(CYCLE_RESET);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HYSTERESIS: r_margin    <= i_cfg_wdata[MARGIN_W-1:0];
                CFG_DEBOUNCE:   r_debounce  <= i_cfg_wdata[DEBOUNCE_W-1:0];
                CFG_CYCLE:      r_cycle_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Length of one duty step in ms, cycle_length / 30.
    btpc_slot_div u_slot_div (
        .i_clk       (i_clk),
        .i_cycle_len (r_cycle_len),
        .o_slot      (w_slot)
    );

    // The whole pipeline moves together whenever the output register can take
    // a new result.
    logic w_adv;
    logic r_v0, r_v1, r_v2, r_v3, r_vo;

    assign w_adv         = !r_vo || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    // Input register.
    logic [TIME_W-1:0]   r0_now;
    logic [SAMPLE_W-1:0] r0_sample;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_now    <= s_axis_tdata[TIME_W-1:0];
            r0_sample <= s_axis_tdata[TIME_W +: SAMPLE_W];
        end
    end

    // Stage 1: cycle overrun check and sample ring update.
    logic [SAMPLE_W-1:0]   r_ring [AVERAGE_LENGTH];
    logic [RING_IDX_W-1:0] r_ring_pos;
    logic [SUM_W-1:0]      r_sum;
    logic [TIME_W-1:0]     r_cycle_start;

    logic [TIME_W-1:0]     w_elapsed;
    logic                  w_overrun;
    logic [SUM_W-1:0]      n_sum;
    logic [RING_IDX_W-1:0] n_ring_pos;
    logic                  w_step1;

    logic [TIME_W-1:0]     r1_now;
    logic [CYCLE_W-1:0]    r1_elapsed;

    assign w_step1   = w_adv && r_v0;
    assign w_elapsed = r0_now - r_cycle_start;
    assign w_overrun = w_elapsed > TIME_W'(r_cycle_len);
    assign n_sum     = r_sum - SUM_W'(r_ring[r_ring_pos]) + SUM_W'(r0_sample);
    assign n_ring_pos = (r_ring_pos == RING_IDX_W'(AVERAGE_LENGTH - 1)) ?
                        '0 : r_ring_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVERAGE_LENGTH; i++) begin
                r_ring[i] <= '0;
            end
            r_ring_pos    <= '0;
            r_sum         <= '0;
            r_cycle_start <= '0;
        end else if (w_step1) begin
            r_ring[r_ring_pos] <= r0_sample;
            r_ring_pos         <= n_ring_pos;
            r_sum              <= n_sum;
            if (w_overrun) begin
                r_cycle_start <= r0_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_now     <= r0_now;
            r1_elapsed <= w_overrun ? '0 : w_elapsed[CYCLE_W-1:0];
        end
    end

    // Stage 2: mean of the ring through a reciprocal multiply.
    // The sum registered in stage 1 is the one that belongs to the item now in
    // stage 1's output register.
    logic [SUM_W+AVG_RECIP_W-1:0]           w_avg_mul;
    logic [SUM_W+AVG_RECIP_W-AVG_SHIFT-1:0] w_avg_q;
    logic [TIME_W-1:0]                      r2_now;
    logic [CYCLE_W-1:0]                     r2_elapsed;
    logic [SAMPLE_W-1:0]                    r2_avg;

    assign w_avg_mul = r_sum * AVG_RECIP_W'(AVG_RECIP);
    assign w_avg_q   = w_avg_mul[SUM_W+AVG_RECIP_W-1:AVG_SHIFT];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_now     <= r1_now;
            r2_elapsed <= r1_elapsed;
            r2_avg     <= w_avg_q[SAMPLE_W-1:0];
        end
    end

    // Stage 3: raw duty = avg * 30 / 4095. With v = q0 * 4096 + lo, the remainder
    // against 4095 is lo + q0, which stays below twice 4095.
    logic [DUTY_PROD_W-1:0] w_v;
    logic [DUTY_W-1:0]      w_q0;
    logic [SAMPLE_W:0]      w_rem;
    logic [DUTY_W:0]        w_q;
    logic [DUTY_W-1:0]      w_raw;

    logic [TIME_W-1:0]      r3_now;
    logic [CYCLE_W-1:0]     r3_elapsed;
    logic [SAMPLE_W-1:0]    r3_avg;
    logic [DUTY_W-1:0]      r3_raw;

    assign w_v   = (DUTY_PROD_W'(r2_avg) << 5) - (DUTY_PROD_W'(r2_avg) << 1);
    assign w_q0  = w_v[DUTY_PROD_W-1:SAMPLE_W];
    assign w_rem = {1'b0, w_v[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(w_q0);
    assign w_q   = (DUTY_W+1)'(w_q0) +
                   (DUTY_W+1)'(w_rem >= (SAMPLE_W+1)'(SAMPLE_FULL_SCALE));
    assign w_raw = (w_q > (DUTY_W+1)'(DUTY_STEPS)) ? DUTY_W'(DUTY_STEPS) : w_q[DUTY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_now     <= r2_now;
            r3_elapsed <= r2_elapsed;
            r3_avg     <= r2_avg;
            r3_raw     <= w_raw;
        end
    end

    // Stage 4: hysteresis, on-window and debounced relay decision.
    logic [DUTY_W-1:0]       r_held;
    logic                    r_relay;
    logic [TIME_W-1:0]       r_last_switch;

    logic [DUTY_W:0]         w_held_hi;
    logic [DUTY_W:0]         w_raw_hi;
    logic [DUTY_W-1:0]       n_held;
    logic [DUTY_W+SLOT_W-1:0] w_window;
    logic                    w_want_on;
    logic [TIME_W-1:0]       w_since_switch;
    logic                    w_switch;
    logic                    w_step4;

    assign w_step4   = w_adv && r_v3;
    assign w_held_hi = (DUTY_W+1)'(r_held) + (DUTY_W+1)'(r_margin);
    assign w_raw_hi  = (DUTY_W+1)'(r3_raw) + (DUTY_W+1)'(r_margin);
    assign n_held    = ((DUTY_W+1)'(r3_raw) > w_held_hi ||
                        w_raw_hi < (DUTY_W+1)'(r_held)) ? r3_raw : r_held;

    assign w_window       = n_held * w_slot;
    assign w_want_on      = (DUTY_W+SLOT_W)'(r3_elapsed) < w_window;
    assign w_since_switch = r3_now - r_last_switch;
    assign w_switch       = (w_want_on != r_relay) &&
                            (w_since_switch > TIME_W'(r_debounce));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= '0;
            r_relay       <= 1'b0;
            r_last_switch <= '0;
        end else if (w_step4) begin
            r_held <= n_held;
            if (w_switch) begin
                r_relay       <= w_want_on;
                r_last_switch <= r3_now;
            end
        end
    end

    // Output register.
    logic                r_out_relay;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [PCT_W-1:0]    r_out_pct;
    logic [SAMPLE_W-1:0] r_out_avg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_relay <= w_switch ? w_want_on : r_relay;
            r_out_duty  <= n_held;
            r_out_pct   <= pct_of_duty(n_held);
            r_out_avg   <= r3_avg;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {7'b0, r_out_avg, r_out_pct, r_out_duty, r_out_relay};

    // Checks.
    a_ring_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_pos < RING_IDX_W'(AVERAGE_LENGTH))
        else $error("ring position out of range");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_W'(AVERAGE_LENGTH * SAMPLE_FULL_SCALE))
        else $error("running sum exceeds ring capacity");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= DUTY_W'(DUTY_STEPS))
        else $error("held duty above step count");

    a_switch_marks_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_relay != $past(r_relay)) |-> r_last_switch == $past(r3_now))
        else $error("relay changed without recording its switch time");

endmodule

>>> hw/rtl/btpc_slot_div.sv
module btpc_slot_div
    import btpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic [CYCLE_W-1:0]   i_cycle_len,
    output logic [SLOT_W-1:0]    o_slot
);

    // Two registered steps: partial products of the reciprocal multiply, then
    // their sum and the final shift.
    logic [HALF_W-1:0]                   w_half;
    logic [HALF_LO_W+SLOT_RECIP_W-1:0]   r_prod_lo;
    logic [HALF_HI_W+SLOT_RECIP_W-1:0]   r_prod_hi;
    logic [SLOT_PROD_W-1:0]              w_prod;
    logic [SLOT_W-1:0]                   r_slot;

    assign w_half = i_cycle_len[CYCLE_W-1:1];

    always_ff @(posedge i_clk) begin
        r_prod_lo <= w_half[HALF_LO_W-1:0] * SLOT_RECIP_W'(SLOT_RECIP);
        r_prod_hi <= w_half[HALF_W-1:HALF_LO_W] * SLOT_RECIP_W'(SLOT_RECIP);
        r_slot    <= w_prod[SLOT_SHIFT +: SLOT_W];
    end

    assign w_prod = (SLOT_PROD_W'(r_prod_hi) << HALF_LO_W) + SLOT_PROD_W'(r_prod_lo);
    assign o_slot = r_slot;

endmodule
